// ===== design/box_filter_3x3_mean_defines.svh =====
// Assertion macros shared by the box filter RTL.
// Depends on nothing; users supply clk_i and rst_ni in scope.
`ifndef BOX_FILTER_3X3_MEAN_DEFINES_SVH
`define BOX_FILTER_3X3_MEAN_DEFINES_SVH

// Condition holds on every clock edge out of reset.
`define BF3M_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BF3M_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BF3M_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bf3m_pkg.sv =====
// Package for the 3x3 box filter: payload structs, register indexes and
// divide-by-nine constants. Depends on nothing.
package bf3m_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  localparam int unsigned PIX_FIELD_W   = 16;
  localparam int unsigned ROW_W         = 16;
  localparam int unsigned COLUMN_W      = 12;
  localparam int unsigned FRAME_WIDTH_W = 13;
  localparam int unsigned CFG_INDEX_W   = 8;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam int unsigned FRAME_WIDTH_RESET  = 640;
  localparam int unsigned FRAME_HEIGHT_RESET = 480;
  localparam int unsigned MIN_DIM            = 3;

  // Sum of nine 16-bit pixels fits in 20 bits.
  localparam int unsigned SUM_W      = 20;
  // floor(x/9) == (x * ceil(2^23/9)) >> 23 for every x below 2^21.
  localparam int unsigned DIV_SHIFT  = 23;
  localparam int unsigned DIV_MULT_W = 20;
  localparam logic [DIV_MULT_W-1:0] DIV9_MULT = DIV_MULT_W'(((1 << DIV_SHIFT) + 8) / 9);
  localparam int unsigned PROD_W     = SUM_W + DIV_MULT_W;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [PIX_FIELD_W-1:0] pixel_value;
    logic                   frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_FIELD_W-1:0] mean_value;
    logic [ROW_W-1:0]       center_row;
    logic [COLUMN_W-1:0]    center_column;
    logic                   frame_last;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [ROW_W-1:0]    center_row;
    logic [COLUMN_W-1:0] center_column;
    logic                frame_last;
  } sum_item_t;

endpackage

// ===== design/bf3m_front.sv =====
// Front end of the box filter: accepts pixels, tracks row/column, keeps the
// line stores and column sums, and pushes window sums. Uses bf3m_pkg.
`include "box_filter_3x3_mean_defines.svh"

module bf3m_front #(
  parameter int unsigned MAX_WIDTH  = bf3m_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = bf3m_pkg::PIXEL_BITS_DEF,
  localparam int unsigned COL_W = $clog2(MAX_WIDTH),
  localparam int unsigned WU_W  = COL_W + 1,
  localparam int unsigned CNT_W = $clog2(bf3m_pkg::QUEUE_DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bf3m_pkg::pixel_in_t            in_data_i,
  input  logic [WU_W-1:0]                width_used_i,
  input  logic [bf3m_pkg::ROW_W-1:0]     height_used_i,
  input  logic [CNT_W-1:0]               queue_count_i,
  output logic                           push_valid_o,
  output bf3m_pkg::sum_item_t            push_data_o
);

  localparam int unsigned PW    = (PIXEL_BITS < bf3m_pkg::PIX_FIELD_W) ?
                                  PIXEL_BITS : bf3m_pkg::PIX_FIELD_W;
  localparam int unsigned CS_W  = PW + 2;
  localparam int unsigned TS_W  = PW + 4;
  localparam int unsigned ROW_W = bf3m_pkg::ROW_W;

  // Entry holds {older row, newer row} for one column.
  logic [2*PW-1:0] line_mem [MAX_WIDTH];

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic             s1_valid_q;
  logic [PW-1:0]    s1_pix_q;
  logic [COL_W-1:0] s1_addr_q;
  logic             s1_interior_q;
  logic             s1_last_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [bf3m_pkg::COLUMN_W-1:0] s1_col_q;
  logic [2*PW-1:0]  rd_q;
  logic             fwd_q;
  logic [2*PW-1:0]  fwd_data_q;

  logic [CS_W-1:0]  cs_q [3];

  logic             s2_valid_q;
  logic [ROW_W-1:0] s2_row_q;
  logic [bf3m_pkg::COLUMN_W-1:0] s2_col_q;
  logic             s2_last_q;

  logic             accept;
  logic [COL_W-1:0] c0, c1, cur_c;
  logic [ROW_W-1:0] r0, r1, cur_r;
  logic [WU_W-1:0]  c_inc;
  logic [ROW_W:0]   r_inc;
  logic             interior, last;
  logic [2*PW-1:0]  rd_sel, wr_data;
  logic [PW-1:0]    top_pix, mid_pix;
  logic [CS_W-1:0]  col_sum;
  logic [TS_W-1:0]  total;
  logic [CNT_W:0]   in_flight;

  assign in_flight  = {1'b0, queue_count_i} + (CNT_W+1)'(s1_valid_q) + (CNT_W+1)'(s2_valid_q);
  assign in_ready_o = in_flight < (CNT_W+1)'(bf3m_pkg::QUEUE_DEPTH);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    c0 = in_data_i.frame_start ? '0 : col_q;
    r0 = in_data_i.frame_start ? '0 : row_q;
    if ({1'b0, c0} >= width_used_i) begin
      c1 = '0;
      r1 = r0 + ROW_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    cur_r = (r1 >= height_used_i) ? '0 : r1;
    cur_c = c1;
    c_inc = {1'b0, cur_c} + WU_W'(1);
    r_inc = {1'b0, cur_r} + (ROW_W+1)'(1);
    if (c_inc >= width_used_i) begin
      col_d = '0;
      row_d = (r_inc >= {1'b0, height_used_i}) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_d = c_inc[COL_W-1:0];
      row_d = cur_r;
    end
    interior = (cur_r >= ROW_W'(2)) && (cur_c >= COL_W'(2));
    last     = (cur_r == height_used_i - ROW_W'(1)) &&
               ({1'b0, cur_c} == width_used_i - WU_W'(1));
  end

  // Take the entry just written when the new read hits the same column.
  assign rd_sel  = fwd_q ? fwd_data_q : rd_q;
  assign top_pix = rd_sel[2*PW-1:PW];
  assign mid_pix = rd_sel[PW-1:0];
  assign wr_data = {mid_pix, s1_pix_q};
  assign col_sum = CS_W'(top_pix) + CS_W'(mid_pix) + CS_W'(s1_pix_q);
  assign total   = TS_W'(cs_q[0]) + TS_W'(cs_q[1]) + TS_W'(cs_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      for (int i = 0; i < 3; i++) cs_q[i] <= '0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q & s1_interior_q;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        fwd_q <= s1_valid_q && (s1_addr_q == cur_c);
      end
      if (s1_valid_q) begin
        cs_q[0] <= cs_q[1];
        cs_q[1] <= cs_q[2];
        cs_q[2] <= col_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q      <= in_data_i.pixel_value[PW-1:0];
      s1_addr_q     <= cur_c;
      s1_interior_q <= interior;
      s1_last_q     <= last;
      s1_row_q      <= cur_r - ROW_W'(1);
      s1_col_q      <= bf3m_pkg::COLUMN_W'(32'(cur_c) - 32'd1);
      rd_q          <= line_mem[cur_c];
      fwd_data_q    <= wr_data;
    end
    if (s1_valid_q) begin
      line_mem[s1_addr_q] <= wr_data;
      s2_row_q            <= s1_row_q;
      s2_col_q            <= s1_col_q;
      s2_last_q           <= s1_last_q;
    end
  end

  assign push_valid_o              = s2_valid_q;
  assign push_data_o.sum           = bf3m_pkg::SUM_W'(total);
  assign push_data_o.center_row    = s2_row_q;
  assign push_data_o.center_column = s2_col_q;
  assign push_data_o.frame_last    = s2_last_q;

  `BF3M_ASSERT_NEXT(a_accept_loads_s1, accept, s1_valid_q, "accepted beat did not reach stage 1")
  `BF3M_ASSERT_NEXT(a_s2_from_s1, !s1_valid_q, !s2_valid_q, "stage 2 valid without stage 1")

endmodule

// ===== design/bf3m_fifo.sv =====
// Short queue between the front and back ends of the box filter.
// Show-ahead read; holds bf3m_pkg::sum_item_t entries.
`include "box_filter_3x3_mean_defines.svh"

module bf3m_fifo #(
  parameter int unsigned DEPTH = bf3m_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  bf3m_pkg::sum_item_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output bf3m_pkg::sum_item_t pop_data_o,
  output logic [CNT_W-1:0]    count_o
);

  bf3m_pkg::sum_item_t entries_q [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]    count_q;
  logic                do_pop;

  assign pop_valid_o = count_q != '0;
  assign pop_data_o  = entries_q[rd_ptr_q];
  assign count_o     = count_q;
  assign do_pop      = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_valid_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_valid_i && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (!push_valid_i && do_pop) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BF3M_ASSERT_IMPL(a_no_overflow, push_valid_i, count_q < CNT_W'(DEPTH), "push into full queue")
  `BF3M_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count out of range")

endmodule

// ===== design/bf3m_back.sv =====
// Back end of the box filter: divides window sums by nine through a
// reciprocal multiply and holds the result beat. Uses bf3m_pkg.
`include "box_filter_3x3_mean_defines.svh"

module bf3m_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  bf3m_pkg::sum_item_t pop_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bf3m_pkg::result_t   out_data_o
);

  logic                                m_valid_q;
  logic [bf3m_pkg::PROD_W-1:0]         m_prod_q;
  logic [bf3m_pkg::ROW_W-1:0]          m_row_q;
  logic [bf3m_pkg::COLUMN_W-1:0]       m_col_q;
  logic                                m_last_q;
  logic                                out_valid_q;
  bf3m_pkg::result_t                   out_data_q;
  logic                                m_ready, o_ready, pop;
  logic [bf3m_pkg::PROD_W-1:0]         quot;

  assign o_ready     = !out_valid_q || out_ready_i;
  assign m_ready     = !m_valid_q || o_ready;
  assign pop_ready_o = m_ready;
  assign pop         = pop_valid_i & m_ready;
  assign quot        = m_prod_q >> bf3m_pkg::DIV_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_ready) m_valid_q <= pop_valid_i;
      if (o_ready) out_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      m_prod_q <= bf3m_pkg::PROD_W'(pop_data_i.sum) *
                  bf3m_pkg::PROD_W'(bf3m_pkg::DIV9_MULT);
      m_row_q  <= pop_data_i.center_row;
      m_col_q  <= pop_data_i.center_column;
      m_last_q <= pop_data_i.frame_last;
    end
    if (m_valid_q && o_ready) begin
      out_data_q.mean_value    <= quot[bf3m_pkg::PIX_FIELD_W-1:0];
      out_data_q.center_row    <= m_row_q;
      out_data_q.center_column <= m_col_q;
      out_data_q.frame_last    <= m_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BF3M_ASSERT_NEXT(a_pop_loads_mul, pop, m_valid_q, "popped beat lost before multiply stage")
  `BF3M_ASSERT_NEXT(a_mul_holds, m_valid_q && !o_ready, m_valid_q && $stable(m_prod_q),
                    "multiply stage changed while stalled")

endmodule

// ===== design/box_filter_3x3_mean.sv =====
// After the pixel below-right of its center is accepted, a result passes the
// line store read, column sum, queue and reciprocal multiply. Throughput: one
// pixel per cycle unless the output stalls; the line store takes one read and
// one write per cycle. Reset clears counters, column sums, queue and handshake
// state at once; line stores need no clearing pass and hold garbage until written.
// Top level of the 3x3 box filter; uses bf3m_pkg and the bf3m_* modules.
module box_filter_3x3_mean #(
  parameter int unsigned MAX_WIDTH  = bf3m_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = bf3m_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bf3m_pkg::pixel_in_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bf3m_pkg::result_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bf3m_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [bf3m_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WU_W  = COL_W + 1;
  localparam int unsigned CNT_W = $clog2(bf3m_pkg::QUEUE_DEPTH + 1);
  localparam int unsigned WIDTH_RESET = (bf3m_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                                        MAX_WIDTH : bf3m_pkg::FRAME_WIDTH_RESET;

  logic [WU_W-1:0]                     width_used_q;
  logic [bf3m_pkg::ROW_W-1:0]          height_used_q;
  logic [bf3m_pkg::FRAME_WIDTH_W-1:0]  fw;
  logic [WU_W-1:0]                     width_clamped;
  logic [bf3m_pkg::ROW_W-1:0]          height_clamped;
  logic                                cfg_write;

  logic                push_valid;
  bf3m_pkg::sum_item_t push_data;
  logic                pop_valid, pop_ready;
  bf3m_pkg::sum_item_t pop_data;
  logic [CNT_W-1:0]    queue_count;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign fw          = cfg_data_i[bf3m_pkg::FRAME_WIDTH_W-1:0];

  always_comb begin
    priority if (32'(fw) < bf3m_pkg::MIN_DIM) begin
      width_clamped = WU_W'(bf3m_pkg::MIN_DIM);
    end else if (32'(fw) > MAX_WIDTH) begin
      width_clamped = WU_W'(MAX_WIDTH);
    end else begin
      width_clamped = WU_W'(fw);
    end
    height_clamped = (32'(cfg_data_i) < bf3m_pkg::MIN_DIM) ?
                     bf3m_pkg::ROW_W'(bf3m_pkg::MIN_DIM) : cfg_data_i;
  end

  // Store the clamped sizes so the counters see legal values only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_used_q  <= WU_W'(WIDTH_RESET);
      height_used_q <= bf3m_pkg::ROW_W'(bf3m_pkg::FRAME_HEIGHT_RESET);
    end else if (cfg_write) begin
      if (cfg_index_i == bf3m_pkg::REG_FRAME_WIDTH) begin
        width_used_q <= width_clamped;
      end else if (cfg_index_i == bf3m_pkg::REG_FRAME_HEIGHT) begin
        height_used_q <= height_clamped;
      end
    end
  end

  bf3m_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .width_used_i  (width_used_q),
    .height_used_i (height_used_q),
    .queue_count_i (queue_count),
    .push_valid_o  (push_valid),
    .push_data_o   (push_data)
  );

  bf3m_fifo #(
    .DEPTH (bf3m_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data),
    .count_o      (queue_count)
  );

  bf3m_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for box_filter_3x3_mean: drives pixel frames and
// register writes, predicts each window mean and compares every result beat.
// Depends on bf3m_pkg and the box_filter_3x3_mean RTL.
module testbench;
  import bf3m_pkg::*;

  localparam int unsigned MAX_W = MAX_WIDTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam logic [CFG_INDEX_W-1:0] SPARE_REG_INDEX = 8'hFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pixel_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  result_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  box_filter_3x3_mean DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: line stores, window, raster position, registers.
  bit [PIX_FIELD_W-1:0] line_older [MAX_W];
  bit [PIX_FIELD_W-1:0] line_newer [MAX_W];
  bit [PIX_FIELD_W-1:0] window [9];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  logic [FRAME_WIDTH_W-1:0] width_reg = FRAME_WIDTH_W'(FRAME_WIDTH_RESET);
  logic [ROW_W-1:0] height_reg = ROW_W'(FRAME_HEIGHT_RESET);
  // Set when the width grows: the next beat restarts the frame so that no
  // line store entry is read before this frame has written it.
  bit restart_pending = 1'b0;

  result_t pending_means [$];
  int unsigned mismatches = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned used_width();
    if (width_reg < MIN_DIM) return MIN_DIM;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned used_height();
    return (height_reg < MIN_DIM) ? MIN_DIM : 32'(height_reg);
  endfunction

  function automatic logic [PIX_FIELD_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return PIX_FIELD_W'($urandom);
    endcase
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  task automatic blur_pixel(input pixel_in_t beat);
    int unsigned w, h, r, c, total;
    bit [PIX_FIELD_W-1:0] top, mid;
    result_t res;
    w = used_width();
    h = used_height();
    if (beat.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    // Counters can sit past the size after a register change.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    top = line_older[c];
    mid = line_newer[c];
    line_older[c] = mid;
    line_newer[c] = beat.pixel_value;
    for (int k = 0; k < 9; k += 3) begin
      window[k] = window[k+1];
      window[k+1] = window[k+2];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = beat.pixel_value;
    if (r >= 2 && c >= 2) begin
      total = 0;
      for (int k = 0; k < 9; k++) total += 32'(window[k]);
      res.mean_value = PIX_FIELD_W'(total / 9);
      res.center_row = ROW_W'(r - 1);
      res.center_column = COLUMN_W'(c - 1);
      res.frame_last = (r == h - 1) && (c == w - 1);
      pending_means.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic set_idle(input int unsigned sender_pct, input int unsigned receiver_pct);
    in_idle_pct = sender_pct;
    out_stall_pct = receiver_pct;
  endtask

  task automatic send_pixel(input logic [PIX_FIELD_W-1:0] value, input logic start);
    pixel_in_t beat;
    beat.pixel_value = value;
    beat.frame_start = start | restart_pending;
    restart_pending = 1'b0;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    blur_pixel(beat);
  endtask

  task automatic send_frame(input int unsigned count, input logic start);
    int unsigned i;
    for (i = 0; i < count; i++) send_pixel(rand_pixel(), start && i == 0);
  endtask

  // Drain the pipe first: registers change only while the block is idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    int unsigned old_width;
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    old_width = used_width();
    if (index == REG_FRAME_WIDTH) width_reg = value[FRAME_WIDTH_W-1:0];
    else if (index == REG_FRAME_HEIGHT) height_reg = value;
    if (used_width() > old_width) restart_pending = 1'b1;
  endtask

  // Reset size 640x480, no frame_start: first results land on row 1.
  task automatic test_reset_size();
    send_frame(2 * FRAME_WIDTH_RESET + 4, 1'b0);
  endtask

  task automatic test_directed_frames();
    int unsigned k;
    write_reg(REG_FRAME_WIDTH, 16'd3);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    for (k = 0; k < 9; k++) send_pixel('1, k == 0);
    // Next frame follows without frame_start.
    for (k = 0; k < 9; k++) send_pixel('0, 1'b0);
    // Stray beat, then restart mid-row; sum of 17 rounds down to 1.
    send_pixel(rand_pixel(), 1'b0);
    for (k = 0; k < 9; k++) send_pixel((k == 4) ? 16'd1 : 16'd2, k == 0);
  endtask

  task automatic test_register_limits();
    int unsigned d;
    for (d = 0; d < MIN_DIM; d++) begin
      write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(d));
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(d));
      send_frame(9, 1'b1);
    end
    write_reg(SPARE_REG_INDEX, '1);
    send_frame(9, 1'b1);
    // Width field all ones clamps to the line store depth.
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    write_reg(REG_FRAME_WIDTH, 16'hE003);
    write_reg(REG_FRAME_HEIGHT, '1);
    send_frame(30, 1'b1);
  endtask

  task automatic test_midframe_resize();
    write_reg(REG_FRAME_WIDTH, 16'd8);
    write_reg(REG_FRAME_HEIGHT, 16'd10);
    send_frame(8 * 5 + 6, 1'b1);
    // Column now past the width: next beat starts a new row.
    write_reg(REG_FRAME_WIDTH, 16'd4);
    send_frame(9, 1'b0);
    // Row now past the height: wraps to row 0.
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    send_frame(16, 1'b0);
    write_reg(REG_FRAME_HEIGHT, 16'd12);
    send_frame(24, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned phase, sent, w, h, frames, n, i;
    logic start;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_idle(0, 0);
        1: set_idle(54, 0);
        2: set_idle(0, 54);
        default: set_idle(37, 37);
      endcase
      sent = 0;
      while (sent < 30) begin
        w = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
        h = $urandom_range(3, 8);
        write_reg(REG_FRAME_WIDTH, {3'($urandom), 13'(w)});
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        frames = $urandom_range(1, 2);
        repeat (frames) begin
          n = w * h;
          // Cut a frame short now and then.
          if ($urandom_range(19) == 0) n = $urandom_range(1, n - 1);
          for (i = 0; i < n; i++) begin
            start = (i == 0) ? ($urandom_range(4) != 0) : ($urandom_range(49) == 0);
            send_pixel(rand_pixel(), start);
          end
          sent += n;
        end
      end
    end
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= out_stall_pct);

  always @(posedge clk_i) begin : check_result
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_means.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: mean %0d row %0d col %0d last %0b",
                                out_data_o.mean_value, out_data_o.center_row,
                                out_data_o.center_column, out_data_o.frame_last));
      end else begin
        want = pending_means.pop_front();
        if (out_data_o.mean_value !== want.mean_value ||
            out_data_o.center_row !== want.center_row ||
            out_data_o.center_column !== want.center_column ||
            out_data_o.frame_last !== want.frame_last) begin
          flag_mismatch($sformatf(
            "mismatch: expected mean %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
            want.mean_value, want.center_row, want.center_column, want.frame_last,
            out_data_o.mean_value, out_data_o.center_row, out_data_o.center_column,
            out_data_o.frame_last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("box_filter_3x3_mean regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_directed_frames();
    test_register_limits();
    test_midframe_resize();
    test_random_frames();
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("box_filter_3x3_mean regression: pass");
    end else begin
      $display("box_filter_3x3_mean regression: fail");
    end
    $finish;
  end

endmodule
